// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, disabled during reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent this cycle, consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/efs_pkg.sv =====
// Types, codes and constants of the per-EtherType frame statistics block.
package efs_pkg;

  localparam int MAC_W    = 48;
  localparam int TYPE_W   = 16;
  localparam int LEN_W    = 11;
  localparam int CNT_W    = 32;
  localparam int BYTES_W  = 48;
  localparam int STATUS_W = 3;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 48;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_MAC    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH = 1'b1;
  localparam logic [LEN_W-1:0]       MIN_LENGTH_RESET = 11'd32;

  // Command modes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REPORT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  // Group (multicast/broadcast) bit: bit 0 of the first address byte
  localparam int GROUP_BIT_POS = 40;

  // Most results a report delivers
  localparam int MAX_RESULTS = 16;

  // Saturation limits on the shared 48-bit adder
  localparam logic [BYTES_W-1:0] LIM32 = 48'h0000_FFFF_FFFF;
  localparam logic [BYTES_W-1:0] LIM48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic              mode;
    logic [MAC_W-1:0]  dest_mac;
    logic [TYPE_W-1:0] ether_type;
    logic [LEN_W-1:0]  frame_length;
  } frame_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TYPE_W-1:0]   entry_type;
    logic [CNT_W-1:0]    frame_total;
    logic [BYTES_W-1:0]  byte_total;
    logic [CNT_W-1:0]    group_total;
    logic [CNT_W-1:0]    mine_total;
    logic                last;
  } result_t;

  // One table row
  typedef struct packed {
    logic [TYPE_W-1:0]  key;
    logic [CNT_W-1:0]   frames;
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   groups;
    logic [CNT_W-1:0]   mines;
  } row_t;

  function automatic result_t make_result(logic [STATUS_W-1:0] status,
                                          logic [TYPE_W-1:0] key, row_t row,
                                          logic last);
    result_t r;
    r.status      = status;
    r.entry_type  = key;
    r.frame_total = row.frames;
    r.byte_total  = row.bytes;
    r.group_total = row.groups;
    r.mine_total  = row.mines;
    r.last        = last;
    return r;
  endfunction

endpackage

// ===== rtl/ethertype_frame_statistics.sv =====
// Per-EtherType received-frame statistics table with sorted insert and report.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -----------------------------
//  command   start, busy, frame                      taken when start & !busy
//  config    cfg_write, cfg_index, cfg_data          taken when cfg_write
//  result    result_strobe, result                   one cycle, cannot be held off
//
// Too-short record or report of an empty table: result in the cycle after start.
// Record: key scan past entries below the type, then an update via the shared saturating
// adder, an insert (a read/write pair per moved row, then a put) or a full-table result.
// Report: one entry per cycle after a registered read of the simple dual-port table memory.
// Synchronous reset empties the table at once (entry count only); no clearing pass.
module ethertype_frame_statistics #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  efs_pkg::frame_t                      frame,
  input  logic                                 cfg_write,
  input  logic [efs_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [efs_pkg::CFG_DATA_W-1:0]       cfg_data,
  output efs_pkg::result_t                     result,
  output logic                                 result_strobe
);
  import efs_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] REP_MAX =
    (TABLE_ENTRIES < MAX_RESULTS) ? CW'(TABLE_ENTRIES) : CW'(MAX_RESULTS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_UPD     = 3'd2;
  localparam logic [2:0] S_UPD_WR  = 3'd3;
  localparam logic [2:0] S_INS_RD  = 3'd4;
  localparam logic [2:0] S_INS_WR  = 3'd5;
  localparam logic [2:0] S_INS_PUT = 3'd6;
  localparam logic [2:0] S_REPORT  = 3'd7;

  logic [2:0]         state;
  logic [CW-1:0]      used;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      sh;
  logic [CW-1:0]      rep_n;
  logic [1:0]         step;
  logic [MAC_W-1:0]   own_mac;
  logic [LEN_W-1:0]   min_length;
  logic [TYPE_W-1:0]  et;
  logic [LEN_W-1:0]   len;
  logic               grp;
  logic               mine;
  row_t               work;
  row_t               new_row;

  // table memory
  row_t               mem [TABLE_ENTRIES];
  row_t               rd_data;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  row_t               wr_data;
  logic               wr_en;

  // shared saturating adder
  logic [BYTES_W-1:0] add_a;
  logic [BYTES_W-1:0] add_b;
  logic [BYTES_W-1:0] add_lim;
  logic [BYTES_W:0]   add_sum;
  logic [BYTES_W-1:0] add_res;

  logic               scan_hit;
  logic               scan_miss;
  logic               rep_last;
  logic               result_strobe_next;

  assign busy = (state != S_IDLE);

  // row built for a new EtherType
  always_comb begin
    new_row.key    = et;
    new_row.frames = CNT_W'(1);
    new_row.bytes  = BYTES_W'(len);
    new_row.groups = CNT_W'(grp);
    new_row.mines  = CNT_W'(mine);
  end

  // scan compare: data at pos is valid in S_SCAN
  assign scan_miss = (pos == used) || (rd_data.key > et);
  assign scan_hit  = (pos != used) && (rd_data.key == et);
  assign rep_last  = (CW'(pos + CW'(1)) == rep_n);

  // read address: next row while scanning or reporting, row below while shifting
  always_comb begin
    unique case (state)
      S_SCAN, S_REPORT: rd_addr = IW'(pos + CW'(1));
      S_INS_RD:         rd_addr = IW'(sh - CW'(1));
      default:          rd_addr = '0;
    endcase
  end

  // write port
  always_comb begin
    wr_en   = (state == S_UPD_WR) || (state == S_INS_WR) || (state == S_INS_PUT);
    wr_addr = (state == S_INS_WR) ? IW'(sh) : IW'(pos);
    unique case (state)
      S_INS_WR:  wr_data = rd_data;
      S_INS_PUT: wr_data = new_row;
      default:   wr_data = work;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // operand select for one counter per step
  always_comb begin
    unique case (step)
      2'd0: begin
        add_a = BYTES_W'(work.frames); add_b = BYTES_W'(1);    add_lim = LIM32;
      end
      2'd1: begin
        add_a = work.bytes;            add_b = BYTES_W'(len);  add_lim = LIM48;
      end
      2'd2: begin
        add_a = BYTES_W'(work.groups); add_b = BYTES_W'(grp);  add_lim = LIM32;
      end
      default: begin
        add_a = BYTES_W'(work.mines);  add_b = BYTES_W'(mine); add_lim = LIM32;
      end
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    add_res = (add_sum > {1'b0, add_lim}) ? add_lim : add_sum[BYTES_W-1:0];
  end

  // strobe for the word the sequencer registers this cycle
  always_comb begin
    unique case (state)
      S_IDLE: begin
        result_strobe_next = start && ((frame.mode == MODE_REPORT) ? (used == '0) :
                                       (frame.frame_length < min_length));
      end
      S_SCAN: begin
        result_strobe_next = !scan_hit && scan_miss && (used == FULL_COUNT);
      end
      S_UPD_WR, S_INS_PUT, S_REPORT: begin
        result_strobe_next = 1'b1;
      end
      default: begin
        result_strobe_next = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      result_strobe <= 1'b0;
      own_mac       <= '0;
      min_length    <= MIN_LENGTH_RESET;
    end else begin
      result_strobe <= result_strobe_next;

      if (cfg_write) begin
        unique case (cfg_index)
          CFG_OWN_MAC:    own_mac    <= cfg_data;
          CFG_MIN_LENGTH: min_length <= cfg_data[LEN_W-1:0];
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            et   <= frame.ether_type;
            len  <= frame.frame_length;
            grp  <= frame.dest_mac[GROUP_BIT_POS];
            mine <= !frame.dest_mac[GROUP_BIT_POS] && (frame.dest_mac == own_mac);
            pos  <= '0;
            if (frame.mode == MODE_REPORT) begin
              if (used == '0) begin
                result <= make_result(ST_EMPTY, '0, '0, 1'b1);
              end else begin
                rep_n <= (used < REP_MAX) ? used : REP_MAX;
                state <= S_REPORT;
              end
            end else if (frame.frame_length < min_length) begin
              result <= make_result(ST_IGNORED, frame.ether_type, '0, 1'b1);
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (scan_hit) begin
            work  <= rd_data;
            step  <= 2'd0;
            state <= S_UPD;
          end else if (scan_miss) begin
            if (used == FULL_COUNT) begin
              result <= make_result(ST_FULL, et, '0, 1'b1);
              state  <= S_IDLE;
            end else if (pos == used) begin
              state <= S_INS_PUT;
            end else begin
              sh    <= used;
              state <= S_INS_RD;
            end
          end else begin
            pos <= pos + CW'(1);
          end
        end

        // one counter per cycle through the shared adder
        S_UPD: begin
          unique case (step)
            2'd0:    work.frames <= add_res[CNT_W-1:0];
            2'd1:    work.bytes  <= add_res;
            2'd2:    work.groups <= add_res[CNT_W-1:0];
            default: work.mines  <= add_res[CNT_W-1:0];
          endcase
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= S_UPD_WR;
          end
        end

        S_UPD_WR: begin
          result <= make_result(ST_COUNTED, work.key, work, 1'b1);
          state  <= S_IDLE;
        end

        S_INS_RD: begin
          state <= S_INS_WR;
        end

        // move one row up per read/write pair
        S_INS_WR: begin
          sh <= sh - CW'(1);
          if (CW'(sh - CW'(1)) == pos) begin
            state <= S_INS_PUT;
          end else begin
            state <= S_INS_RD;
          end
        end

        S_INS_PUT: begin
          result <= make_result(ST_COUNTED, new_row.key, new_row, 1'b1);
          used   <= used + CW'(1);
          state  <= S_IDLE;
        end

        S_REPORT: begin
          result <= make_result(ST_REPORT, rd_data.key, rd_data, rep_last);
          pos    <= pos + CW'(1);
          if (rep_last) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/efs_checker.sv =====
// Port-level checks of the frame statistics block, bound to its top level.
`include "assert_macros.svh"

module efs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            busy,
  input efs_pkg::result_t                result,
  input logic                            result_strobe
);
  import efs_pkg::*;

  // the final word of a command frees the block
  `ASSERT_ALWAYS(a_last_frees, clk, rst, result_strobe && result.last |-> !busy, "busy after last word")
  // more words to come: block stays busy
  `ASSERT_ALWAYS(a_more_busy, clk, rst, result_strobe && !result.last |-> busy, "idle before last word")
  // only reports deliver more than one word
  `ASSERT_ALWAYS(a_single_last, clk, rst, result_strobe && (result.status != ST_REPORT) |-> result.last, "single word without last")
  // dropped, ignored and empty words carry no counts
  `ASSERT_ALWAYS(a_zero_totals, clk, rst, result_strobe && (result.status == ST_IGNORED || result.status == ST_FULL || result.status == ST_EMPTY) |-> (result.frame_total == '0) && (result.byte_total == '0), "nonzero totals")
  // report words come back to back
  `ASSERT_NEXT(a_report_run, clk, rst, result_strobe && (result.status == ST_REPORT) && !result.last, result_strobe && (result.status == ST_REPORT), "gap in report")

endmodule

bind ethertype_frame_statistics efs_checker u_efs_checker (
  .clk           (clk),
  .rst           (rst),
  .busy          (busy),
  .result        (result),
  .result_strobe (result_strobe)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the per-EtherType frame statistics table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import efs_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int POOL_SIZE    = 22;
  localparam int PHASES       = 4;
  localparam int PHASE_WORDS  = 29;
  localparam int DRAIN_CYCLES = 80;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PRINT_LIMIT  = 40;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic                   busy;
  frame_t                 frame     = '0;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  result_t                result;
  logic                   result_strobe;

  ethertype_frame_statistics #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .frame         (frame),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result        (result),
    .result_strobe (result_strobe)
  );

  always #6 clk = ~clk;

  // Shadow copy of the statistics table and its registers
  row_t              stat_rows[ENTRIES];
  int                entry_count = 0;
  logic [MAC_W-1:0]  own_mac_cfg = '0;
  logic [LEN_W-1:0]  min_len_cfg = MIN_LENGTH_RESET;

  frame_t            frames_to_send[$];
  result_t           due_results[$];
  logic [TYPE_W-1:0] type_pool[POOL_SIZE];
  result_t           want;
  int                mismatches   = 0;
  int                idle_left    = 0;
  int                quiet_cycles = 0;

  // Apply one accepted frame word to the shadow table, queue the results it causes
  function automatic void apply_frame(frame_t f);
    result_t          r;
    logic             grp;
    logic             mine;
    int               pos;
    int               n;
    logic [BYTES_W:0] sum;
    r = '0;
    r.last = 1'b1;
    if (f.mode == MODE_REPORT) begin
      if (entry_count == 0) begin
        r.status = ST_EMPTY;
        due_results.push_back(r);
      end else begin
        n = (entry_count < MAX_RESULTS) ? entry_count : MAX_RESULTS;
        for (int i = 0; i < n; i++) begin
          r.status      = ST_REPORT;
          r.entry_type  = stat_rows[i].key;
          r.frame_total = stat_rows[i].frames;
          r.byte_total  = stat_rows[i].bytes;
          r.group_total = stat_rows[i].groups;
          r.mine_total  = stat_rows[i].mines;
          r.last        = (i == n - 1);
          due_results.push_back(r);
        end
      end
      return;
    end

    r.entry_type = f.ether_type;
    if (f.frame_length < min_len_cfg) begin
      r.status = ST_IGNORED;
      due_results.push_back(r);
      return;
    end

    grp  = f.dest_mac[GROUP_BIT_POS];
    mine = !grp && (f.dest_mac == own_mac_cfg);

    // sorted search
    pos = 0;
    while (pos < entry_count && stat_rows[pos].key < f.ether_type) pos++;

    if (pos < entry_count && stat_rows[pos].key == f.ether_type) begin
      // saturating update of an existing row
      if (stat_rows[pos].frames != '1) stat_rows[pos].frames = stat_rows[pos].frames + 1;
      sum = {1'b0, stat_rows[pos].bytes} + (BYTES_W+1)'(f.frame_length);
      stat_rows[pos].bytes = sum[BYTES_W] ? LIM48 : sum[BYTES_W-1:0];
      if (grp && stat_rows[pos].groups != '1)
        stat_rows[pos].groups = stat_rows[pos].groups + 1;
      if (mine && stat_rows[pos].mines != '1)
        stat_rows[pos].mines = stat_rows[pos].mines + 1;
    end else begin
      if (entry_count >= ENTRIES) begin
        r.status = ST_FULL;
        due_results.push_back(r);
        return;
      end
      // open a slot and insert in order
      for (int i = entry_count; i > pos; i--) stat_rows[i] = stat_rows[i-1];
      stat_rows[pos].key    = f.ether_type;
      stat_rows[pos].frames = 1;
      stat_rows[pos].bytes  = BYTES_W'(f.frame_length);
      stat_rows[pos].groups = CNT_W'(grp);
      stat_rows[pos].mines  = CNT_W'(mine);
      entry_count++;
    end

    r.status      = ST_COUNTED;
    r.entry_type  = stat_rows[pos].key;
    r.frame_total = stat_rows[pos].frames;
    r.byte_total  = stat_rows[pos].bytes;
    r.group_total = stat_rows[pos].groups;
    r.mine_total  = stat_rows[pos].mines;
    due_results.push_back(r);
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[MAC_W-1:0];
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic void queue_frame(logic mode, logic [MAC_W-1:0] dest,
                                      logic [TYPE_W-1:0] et, logic [LEN_W-1:0] len);
    frame_t f;
    f.mode         = mode;
    f.dest_mac     = dest;
    f.ether_type   = et;
    f.frame_length = len;
    frames_to_send.push_back(f);
  endfunction

  // Random word: destinations cluster around own MAC, types around a small pool,
  // lengths around the minimum
  function automatic void queue_random_frame();
    logic              mode;
    logic [MAC_W-1:0]  dest;
    logic [TYPE_W-1:0] et;
    logic [LEN_W-1:0]  len;
    logic [63:0]       bits;
    int                roll;
    bits = {$urandom(), $urandom()};
    mode = ($urandom_range(0, 99) < 10) ? MODE_REPORT : MODE_RECORD;

    roll = $urandom_range(0, 99);
    if (roll < 30)      dest = own_mac_cfg;
    else if (roll < 45) dest = own_mac_cfg ^ (48'd1 << GROUP_BIT_POS);
    else if (roll < 60) dest = own_mac_cfg ^ (48'd1 << $urandom_range(0, MAC_W - 1));
    else                dest = bits[MAC_W-1:0];

    if ($urandom_range(0, 99) < 80) et = type_pool[$urandom_range(0, POOL_SIZE - 1)];
    else                            et = bits[63:48];

    roll = $urandom_range(0, 99);
    if (roll < 20)      len = min_len_cfg;
    else if (roll < 30) len = min_len_cfg - 1'b1;
    else if (roll < 38) len = '1;
    else if (roll < 43) len = '0;
    else                len = LEN_W'($urandom_range(0, 2047));

    queue_frame(mode, dest, et, len);
  endfunction

  // Register writes; only called while the block is idle
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Upper bits of the min_length write carry noise that must be dropped
  task automatic configure(logic [MAC_W-1:0] mac, logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] data;
    data = random_mac();
    data[LEN_W-1:0] = len;
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_MIN_LENGTH, data);
    own_mac_cfg = mac;
    min_len_cfg = len;
  endtask

  // Wait until every queued word went in and every result came out
  task automatic wait_idle();
    @(negedge clk);
    while (frames_to_send.size() != 0 || start || busy || due_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want_v);
    if (got !== want_v)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want_v));
  endtask

  // Command driver: takes words from the queue, holds them until accepted
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        apply_frame(frame);
        idle_left = pick_gap();
      end
      if (idle_left == 0 && frames_to_send.size() != 0) begin
        start <= 1'b1;
        frame <= frames_to_send.pop_front();
      end else begin
        start <= 1'b0;
        if (idle_left > 0) idle_left = idle_left - 1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing due, status %0d type %h",
                                  result.status, result.entry_type));
      end else begin
        want = due_results.pop_front();
        check_field("status",      64'(result.status),      64'(want.status));
        check_field("entry_type",  64'(result.entry_type),  64'(want.entry_type));
        check_field("frame_total", 64'(result.frame_total), 64'(want.frame_total));
        check_field("byte_total",  64'(result.byte_total),  64'(want.byte_total));
        check_field("group_total", 64'(result.group_total), 64'(want.group_total));
        check_field("mine_total",  64'(result.mine_total),  64'(want.mine_total));
        check_field("last",        64'(result.last),        64'(want.last));
      end
    end
  end

  // Watchdog on cycles where no word moves either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[ethertype_frame_statistics] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    type_pool[0] = 16'h0000;
    type_pool[1] = 16'hFFFF;
    type_pool[2] = 16'h0800;
    type_pool[3] = 16'h86DD;
    for (int i = 4; i < POOL_SIZE; i++) type_pool[i] = TYPE_W'($urandom_range(0, 16'hFFFF));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: own MAC zero, minimum 32
    queue_frame(MODE_REPORT, '0, '0, '0);
    queue_frame(MODE_RECORD, 48'h0, 16'h0800, 11'd0);
    queue_frame(MODE_RECORD, 48'h0, 16'h0800, 11'd31);
    queue_frame(MODE_RECORD, 48'h0, 16'h0800, 11'd32);
    queue_frame(MODE_RECORD, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 11'd2047);
    queue_frame(MODE_RECORD, 48'h0100_5E00_0001, 16'h0000, 11'd64);
    // own address except for the group bit: group, not ours
    queue_frame(MODE_RECORD, 48'h0100_0000_0000, 16'h0800, 11'd1500);
    queue_frame(MODE_REPORT, '1, '1, '1);
    wait_idle();

    configure(48'h02A4_5C71_9E3B, 11'd0);
    queue_frame(MODE_RECORD, own_mac_cfg, 16'h86DD, 11'd0);
    queue_frame(MODE_RECORD, own_mac_cfg ^ 48'd1, 16'h0806, 11'd60);
    queue_frame(MODE_RECORD, own_mac_cfg | (48'd1 << GROUP_BIT_POS), 16'h8100, 11'd100);
    queue_frame(MODE_REPORT, '0, '0, '0);
    wait_idle();

    // all-ones own MAC has the group bit, so nothing counts as ours
    configure(48'hFFFF_FFFF_FFFF, 11'd2047);
    queue_frame(MODE_RECORD, own_mac_cfg, 16'h0800, 11'd2046);
    queue_frame(MODE_RECORD, own_mac_cfg, 16'h88CC, 11'd2047);
    queue_frame(MODE_REPORT, '0, '0, '0);

    // random phases, each under its own settings
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          configure(random_mac() & ~(48'd1 << GROUP_BIT_POS), LEN_W'($urandom_range(0, 96)));
        end
        1: begin
          configure('0, '0);
        end
        2: begin
          configure(random_mac(), '1);
        end
        default: begin
          configure(random_mac() & ~(48'd1 << GROUP_BIT_POS),
                    LEN_W'($urandom_range(0, 2047)));
        end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) queue_random_frame();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("[ethertype_frame_statistics] OK");
    end else begin
      $display("[ethertype_frame_statistics] ERROR");
    end
    $finish;
  end

endmodule
